// File: hw/rtl/sdt_pkg.sv
package sdt_pkg;

   // Table depth used when the top level is not overridden
   localparam int DEFAULT_CAPACITY = 16;

   // Packed date key: year in bits 22..9, month in 8..5, day in 4..0.
   // Comparing keys as unsigned numbers orders dates by year, month, then day.
   localparam int KEY_W = 23;

   typedef logic [KEY_W-1:0] date_key_type;

   // Operation codes carried in req_tuser
   localparam logic [1:0] FUNC_ADD    = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_GET    = 2'd2;

endpackage

// File: hw/rtl/sorted_date_table_core.sv
// Operation: add reads and compares/moves entries from the top down until the new key fits,
// remove walks every entry up to the count, read fetches one entry, and a refused add, a failed
// read or an unknown operation goes straight to the result register.
// Throughput: one item at a time; the table memory (one write and one read port) and the compare
// logic are stepped by the sequencer, so the next item is taken once the current one has finished.
// Reset: synchronous, active high; clears the count, the sequencer and the output valid.
module sorted_date_table_core #(
   parameter int CAPACITY = sdt_pkg::DEFAULT_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // year[13:0], month[17:14], day[22:18], position[26:23]
   input  logic [1:0]  req_tuser,   // func[1:0]
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_year[13:0], out_month[17:14], out_day[22:18],
                                    // entry_count[27:23]
   output logic [0:0]  rsp_tuser    // ok[0]
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   // Sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ADD_RD = 3'd1;
   localparam logic [2:0] ST_ADD_CK = 3'd2;
   localparam logic [2:0] ST_REM_RD = 3'd3;
   localparam logic [2:0] ST_REM_CK = 3'd4;
   localparam logic [2:0] ST_GET_RD = 3'd5;
   localparam logic [2:0] ST_GET_CK = 3'd6;
   localparam logic [2:0] ST_FIN    = 3'd7;

   // Table memory and its registered read data
   sdt_pkg::date_key_type date_mem_ff [CAPACITY];
   sdt_pkg::date_key_type rd_ff;

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         idx_ff, idx_in;
   sdt_pkg::date_key_type key_ff, key_in;
   logic [3:0]            pos_ff, pos_in;
   logic                  found_ff, found_in;
   logic                  ok_ff, ok_in;
   sdt_pkg::date_key_type dat_ff, dat_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   sdt_pkg::date_key_type rsp_key_ff, rsp_key_in;
   logic [4:0]            rsp_count_ff, rsp_count_in;

   logic                  mem_we;
   logic [AW-1:0]         mem_wa;
   sdt_pkg::date_key_type mem_wd;
   logic [AW-1:0]         mem_ra;
   logic [CW+4:0]         count_ext;
   sdt_pkg::date_key_type req_key;

   assign req_key   = {req_tdata[13:0], req_tdata[17:14], req_tdata[22:18]};
   assign count_ext = {5'b0, count_ff};

   // Sequencer: one memory read or one compare/move per cycle
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      ok_in        = ok_ff;
      dat_in       = dat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_count_in = rsp_count_ff;
      mem_we       = 1'b0;
      mem_wa       = '0;
      mem_wd       = key_ff;
      mem_ra       = '0;

      // drop the result once taken
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               key_in   = req_key;
               pos_in   = req_tdata[26:23];
               found_in = 1'b0;
               ok_in    = 1'b0;
               dat_in   = '0;
               idx_in   = '0;
               unique case (req_tuser)
                  sdt_pkg::FUNC_ADD: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        state_in = ST_FIN;
                     end else begin
                        idx_in   = count_ff;
                        state_in = ST_ADD_RD;
                     end
                  end
                  sdt_pkg::FUNC_REMOVE: begin
                     state_in = ST_REM_RD;
                  end
                  sdt_pkg::FUNC_GET: begin
                     if (16'(req_tdata[26:23]) < 16'(count_ff)) begin
                        state_in = ST_GET_RD;
                     end else begin
                        state_in = ST_FIN;
                     end
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end

         // walk down from the top; fetch the entry below the hole
         ST_ADD_RD: begin
            if (idx_ff == '0) begin
               mem_we   = 1'b1;
               mem_wa   = '0;
               mem_wd   = key_ff;
               count_in = count_ff + CW'(1);
               ok_in    = 1'b1;
               state_in = ST_FIN;
            end else begin
               mem_ra   = AW'(idx_ff - CW'(1));
               state_in = ST_ADD_CK;
            end
         end

         // move a greater entry up, else drop the new key into the hole
         ST_ADD_CK: begin
            mem_we = 1'b1;
            mem_wa = AW'(idx_ff);
            if (rd_ff > key_ff) begin
               mem_wd   = rd_ff;
               idx_in   = idx_ff - CW'(1);
               state_in = ST_ADD_RD;
            end else begin
               mem_wd   = key_ff;
               count_in = count_ff + CW'(1);
               ok_in    = 1'b1;
               state_in = ST_FIN;
            end
         end

         // walk up from the bottom; finish at the count
         ST_REM_RD: begin
            if (idx_ff == count_ff) begin
               ok_in = found_ff;
               if (found_ff) begin
                  count_in = count_ff - CW'(1);
               end
               state_in = ST_FIN;
            end else begin
               mem_ra   = AW'(idx_ff);
               state_in = ST_REM_CK;
            end
         end

         // after the match, move each entry down by one
         ST_REM_CK: begin
            if (found_ff) begin
               mem_we = 1'b1;
               mem_wa = AW'(idx_ff - CW'(1));
               mem_wd = rd_ff;
            end else if (rd_ff == key_ff) begin
               found_in = 1'b1;
            end
            idx_in   = idx_ff + CW'(1);
            state_in = ST_REM_RD;
         end

         ST_GET_RD: begin
            mem_ra   = AW'(pos_ff);
            state_in = ST_GET_CK;
         end

         ST_GET_CK: begin
            ok_in    = 1'b1;
            dat_in   = rd_ff;
            state_in = ST_FIN;
         end

         // hold until the output register is free, then load the result
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_key_in   = dat_ff;
               rsp_count_in = count_ext[4:0];
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      key_ff       <= key_in;
      pos_ff       <= pos_in;
      found_ff     <= found_in;
      ok_ff        <= ok_in;
      dat_ff       <= dat_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Table memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         date_mem_ff[mem_wa] <= mem_wd;
      end
      rd_ff <= date_mem_ff[mem_ra];
   end

   assign req_tready   = (state_ff == ST_IDLE);
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_ok_ff;
   assign rsp_tdata    = {4'b0, rsp_count_ff, rsp_key_ff[4:0], rsp_key_ff[8:5],
                          rsp_key_ff[22:9]};

endmodule
